// File: rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants for the rational arithmetic unit
// holds the transfer payload structs, opcode codes, sequencer states and widths
// ----------------------------------------------------------------------------
package rar_pkg;

	// operand geometry
	localparam int OPW  = 16;             // numerator width
	localparam int DENW = OPW - 1;        // denominator width
	localparam int NW   = 2 * OPW + 1;    // signed working width of products and sums
	localparam int MW   = 2 * OPW;        // magnitude width
	localparam int CNTW = $clog2(MW);     // step counter and shift count width
	localparam int RESW = 32;             // result numerator width
	localparam int RDW  = 31;             // result denominator width

	// opcodes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_NEG = 3'd4;
	localparam logic [2:0] OP_CMP = 3'd5;

	typedef struct packed {
		logic [2:0]              opcode;
		logic signed [OPW-1:0]   a_num;
		logic [DENW-1:0]         a_den;
		logic signed [OPW-1:0]   b_num;
		logic [DENW-1:0]         b_den;
	} in_t;

	typedef struct packed {
		logic signed [RESW-1:0]  res_num;
		logic [RDW-1:0]          res_den;
		logic                    greater;
		logic                    less;
		logic                    div_zero;
	} out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_PREP,
		ST_ABS,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;

endpackage

// File: rtl/core/rar_sub_unit.sv
// ----------------------------------------------------------------------------
// rar_sub_unit: shared subtract and compare unit
// one unsigned subtractor used by both the gcd loop and the divider
// ----------------------------------------------------------------------------
module rar_sub_unit #(
	parameter int WD = 33
) (
	input  logic [WD-1:0] a,
	input  logic [WD-1:0] b,
	output logic [WD-1:0] diff,
	output logic          ge
);

	logic [WD:0] full;

	// borrow out of the top bit means a < b
	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[WD-1:0];
	assign ge   = ~full[WD];

endmodule

// File: rtl/core/rational_arith_reduce_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce_unit: rational add/sub/mul/div/negate/compare with
// reduction to lowest terms
// ----------------------------------------------------------------------------
// One item is handled at a time. After the input transfer, one shared signed
// multiplier forms the three cross products in states MUL0..MUL2, PREP builds
// the raw numerator and denominator and moves the sign to the numerator, and
// ABS takes magnitudes. A binary gcd loop then runs on the shared subtractor,
// one shift, subtract or operand swap per cycle, and latches the gcd when u
// reaches zero. The numerator and denominator are then divided by the gcd
// with a restoring divider on the same subtractor, numerator first. Compare
// goes from MUL2 straight to FIN, unused opcodes from idle to FIN. The result
// sits in an output register, so the next input can be taken while a finished
// result waits for its output transfer. in_ready is high only while the
// sequencer is idle, which starts the cycle after the output register is
// loaded.
// ----------------------------------------------------------------------------
module rational_arith_reduce_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rar_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output rar_pkg::out_t  out_data
);

	localparam int OPW  = rar_pkg::OPW;
	localparam int NW   = rar_pkg::NW;
	localparam int MW   = rar_pkg::MW;
	localparam int CNTW = rar_pkg::CNTW;
	localparam int XW   = NW + rar_pkg::RESW;

	rar_pkg::state_t state_q, state_nx;
	rar_pkg::in_t    in_q;
	rar_pkg::out_t   out_q;
	logic            out_valid_q;

	// product registers
	logic signed [NW-1:0] x_q, y_q, z_q;
	// raw fraction after build
	logic signed [NW-1:0] n_q, d_q;
	logic                 flag_q;
	logic                 neg_q;
	// magnitudes and gcd loop
	logic [MW-1:0]        nm_q, dm_q, u_q, v_q, g_q;
	logic [CNTW-1:0]      k_q, cnt_q;
	// divider
	logic [MW-1:0]        dq_q, qn_q;
	logic [MW:0]          r_q;

	// multiplier
	logic signed [OPW:0]       ma, mb;
	logic signed [2*OPW+1:0]   prod;

	// shared subtractor
	logic [MW:0] su_a, su_b, su_diff;
	logic        su_ge;
	logic [MW:0] div_t;

	// build stage
	logic signed [NW-1:0] bld_n, bld_d;

	// final result
	logic signed [NW-1:0] fin_n;
	logic signed [XW-1:0] fin_x;
	logic [MW-1:0]        qd_fin;
	logic [MW-1:0]        g_new;

	logic in_xfer, out_xfer, fin_load, is_arith;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid_q && out_ready;
	assign fin_load = (state_q == rar_pkg::ST_FIN) && (!out_valid_q || out_ready);
	assign is_arith = (in_q.opcode != rar_pkg::OP_CMP) && (in_q.opcode[2:1] != 2'b11);

	rar_sub_unit #(
		.WD(MW + 1)
	) u_sub (
		.a   (su_a),
		.b   (su_b),
		.diff(su_diff),
		.ge  (su_ge)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			rar_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (in_data.opcode inside {rar_pkg::OP_ADD, rar_pkg::OP_SUB,
							rar_pkg::OP_MUL, rar_pkg::OP_DIV, rar_pkg::OP_NEG,
							rar_pkg::OP_CMP})
						state_nx = rar_pkg::ST_MUL0;
					else
						state_nx = rar_pkg::ST_FIN;
				end
			end
			rar_pkg::ST_MUL0: state_nx = rar_pkg::ST_MUL1;
			rar_pkg::ST_MUL1: state_nx = rar_pkg::ST_MUL2;
			rar_pkg::ST_MUL2: state_nx = is_arith ? rar_pkg::ST_PREP : rar_pkg::ST_FIN;
			rar_pkg::ST_PREP: state_nx = rar_pkg::ST_ABS;
			rar_pkg::ST_ABS:  state_nx = rar_pkg::ST_GCD;
			rar_pkg::ST_GCD: begin
				if (u_q == '0)
					state_nx = rar_pkg::ST_DIVN;
			end
			rar_pkg::ST_DIVN: begin
				if (cnt_q == CNTW'(MW - 1))
					state_nx = rar_pkg::ST_DIVD;
			end
			rar_pkg::ST_DIVD: begin
				if (cnt_q == CNTW'(MW - 1))
					state_nx = rar_pkg::ST_FIN;
			end
			rar_pkg::ST_FIN: begin
				if (fin_load)
					state_nx = rar_pkg::ST_IDLE;
			end
			default: state_nx = rar_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake, multiplier and subtractor operand select
	always_comb begin
		in_ready = (state_q == rar_pkg::ST_IDLE);
		ma = (OPW + 1)'(in_q.a_num);
		mb = $signed({2'b00, in_q.b_den});
		su_a = {1'b0, u_q};
		su_b = {1'b0, v_q};
		div_t = {r_q[MW-1:0], dq_q[MW-1]};
		case (state_q)
			rar_pkg::ST_MUL0: begin
				// an*bn for multiply, an*bd otherwise
				ma = (OPW + 1)'(in_q.a_num);
				if (in_q.opcode == rar_pkg::OP_MUL)
					mb = (OPW + 1)'(in_q.b_num);
				else
					mb = $signed({2'b00, in_q.b_den});
			end
			rar_pkg::ST_MUL1: begin
				ma = (OPW + 1)'(in_q.b_num);
				mb = $signed({2'b00, in_q.a_den});
			end
			rar_pkg::ST_MUL2: begin
				// ad*bn for divide, ad*bd otherwise
				ma = $signed({2'b00, in_q.a_den});
				if (in_q.opcode == rar_pkg::OP_DIV)
					mb = (OPW + 1)'(in_q.b_num);
				else
					mb = $signed({2'b00, in_q.b_den});
			end
			rar_pkg::ST_DIVN, rar_pkg::ST_DIVD: begin
				su_a = div_t;
				su_b = {1'b0, g_q};
			end
			default: begin
				su_a = {1'b0, u_q};
				su_b = {1'b0, v_q};
			end
		endcase
	end

	assign prod = ma * mb;

	// raw numerator and denominator by opcode
	always_comb begin
		bld_n = x_q;
		bld_d = z_q;
		case (in_q.opcode)
			rar_pkg::OP_ADD: bld_n = x_q + y_q;
			rar_pkg::OP_SUB: bld_n = x_q - y_q;
			rar_pkg::OP_NEG: begin
				bld_n = -NW'(in_q.a_num);
				bld_d = $signed({{(NW - rar_pkg::DENW){1'b0}}, in_q.a_den});
			end
			default: bld_n = x_q;
		endcase
	end

	assign g_new  = v_q << k_q;
	assign qd_fin = {dq_q[MW-2:0], su_ge};
	assign fin_n  = neg_q ? -$signed({1'b0, qn_q}) : $signed({1'b0, qn_q});
	assign fin_x  = XW'(fin_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rar_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (out_xfer)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer)
			in_q <= in_data;
		case (state_q)
			rar_pkg::ST_MUL0: x_q <= prod[NW-1:0];
			rar_pkg::ST_MUL1: y_q <= prod[NW-1:0];
			rar_pkg::ST_MUL2: z_q <= prod[NW-1:0];
			rar_pkg::ST_PREP: begin
				// zero denominator forced to 1 and flagged
				flag_q <= (bld_d == '0);
				if (bld_d == '0) begin
					n_q <= bld_n;
					d_q <= NW'(1);
				end else if (bld_d < 0) begin
					n_q <= -bld_n;
					d_q <= -bld_d;
				end else begin
					n_q <= bld_n;
					d_q <= bld_d;
				end
			end
			rar_pkg::ST_ABS: begin
				neg_q <= n_q[NW-1];
				nm_q  <= n_q[NW-1] ? MW'(-n_q) : MW'(n_q);
				dm_q  <= MW'(d_q);
				u_q   <= n_q[NW-1] ? MW'(-n_q) : MW'(n_q);
				v_q   <= MW'(d_q);
				k_q   <= '0;
			end
			rar_pkg::ST_GCD: begin
				// binary gcd, one shift, subtract or swap per cycle
				if (u_q == '0) begin
					g_q   <= g_new;
					dq_q  <= nm_q;
					r_q   <= '0;
					cnt_q <= '0;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + CNTW'(1);
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (su_ge) begin
					u_q <= su_diff[MW-1:0];
				end else begin
					// both odd and u < v: swap so the next cycle subtracts
					u_q <= v_q;
					v_q <= u_q;
				end
			end
			rar_pkg::ST_DIVN: begin
				if (cnt_q == CNTW'(MW - 1)) begin
					qn_q  <= qd_fin;
					dq_q  <= dm_q;
					r_q   <= '0;
					cnt_q <= '0;
				end else begin
					r_q   <= su_ge ? su_diff : div_t;
					dq_q  <= qd_fin;
					cnt_q <= cnt_q + CNTW'(1);
				end
			end
			rar_pkg::ST_DIVD: begin
				r_q   <= su_ge ? su_diff : div_t;
				dq_q  <= qd_fin;
				cnt_q <= cnt_q + CNTW'(1);
			end
			default: begin
			end
		endcase
		if (fin_load) begin
			out_q.res_num  <= '0;
			out_q.res_den  <= rar_pkg::RDW'(1);
			out_q.greater  <= 1'b0;
			out_q.less     <= 1'b0;
			out_q.div_zero <= 1'b0;
			if (in_q.opcode == rar_pkg::OP_CMP) begin
				out_q.greater <= (x_q > y_q);
				out_q.less    <= (x_q < y_q);
			end else if (is_arith) begin
				out_q.res_num  <= fin_x[rar_pkg::RESW-1:0];
				out_q.res_den  <= rar_pkg::RDW'(dq_q);
				out_q.div_zero <= flag_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	// a delivered denominator is never zero
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.res_den != '0))
		else $error("zero result denominator");

	// the flag always comes with a unit denominator
	a_flag_den: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.div_zero) |-> (out_q.res_den == rar_pkg::RDW'(1)))
		else $error("div_zero without unit denominator");

	// gcd loop never sees a zero second operand
	a_gcd_v: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rar_pkg::ST_GCD) |-> (v_q != '0))
		else $error("gcd operand zero");

	// no new input transfer while an item is in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ready)
		else $error("input taken while busy");

	// compare never sets both flags
	a_cmp_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.greater && out_q.less))
		else $error("greater and less both set");
`endif

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rational_arith_reduce_unit
// a directed set of corner items, then random items under three idling mixes,
// with a long output stall and a drain pause; every result is predicted
// ----------------------------------------------------------------------------
class frac_scoreboard;
	rar_pkg::out_t expected_q[$];
	int errors = 0;

	static function longint unsigned gcd_of(longint unsigned x, longint unsigned y);
		longint unsigned r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// reduce n/d to lowest terms, sign on the numerator, zero denominator flagged
	static function rar_pkg::out_t reduce(longint n, longint d);
		rar_pkg::out_t r;
		longint unsigned mag, g;
		r = '0;
		if (d == 0) begin
			r.div_zero = 1'b1;
			d = 1;
		end
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		mag = (n < 0) ? longint'(-n) : n;
		g = gcd_of(mag, d);
		if (g == 0)
			g = 1;
		n = n / longint'(g);
		d = d / longint'(g);
		r.res_num = n[31:0];
		r.res_den = d[30:0];
		return r;
	endfunction

	function void note(rar_pkg::in_t it);
		rar_pkg::out_t r;
		longint an, ad, bn, bd, lhs, rhs;
		an = it.a_num;
		ad = it.a_den;
		bn = it.b_num;
		bd = it.b_den;
		lhs = an * bd;
		rhs = bn * ad;
		r = '0;
		r.res_den = 1;
		case (it.opcode)
			rar_pkg::OP_ADD: r = reduce(lhs + rhs, ad * bd);
			rar_pkg::OP_SUB: r = reduce(lhs - rhs, ad * bd);
			rar_pkg::OP_MUL: r = reduce(an * bn, ad * bd);
			rar_pkg::OP_DIV: r = reduce(lhs, ad * bn);
			rar_pkg::OP_NEG: r = reduce(-an, ad);
			rar_pkg::OP_CMP: begin
				r.greater = lhs > rhs;
				r.less    = lhs < rhs;
			end
			default: ;
		endcase
		expected_q.push_back(r);
	endfunction

	function void check(rar_pkg::out_t got);
		rar_pkg::out_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (got.res_num !== e.res_num) begin
			$display("%0t: res_num expected %0d actual %0d", $time, e.res_num, got.res_num);
			errors++;
		end
		if (got.res_den !== e.res_den) begin
			$display("%0t: res_den expected %0d actual %0d", $time, e.res_den, got.res_den);
			errors++;
		end
		if (got.greater !== e.greater) begin
			$display("%0t: greater expected %b actual %b", $time, e.greater, got.greater);
			errors++;
		end
		if (got.less !== e.less) begin
			$display("%0t: less expected %b actual %b", $time, e.less, got.less);
			errors++;
		end
		if (got.div_zero !== e.div_zero) begin
			$display("%0t: div_zero expected %b actual %b", $time, e.div_zero, got.div_zero);
			errors++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rar_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rar_pkg::out_t out_data;

	frac_scoreboard sb = new();

	// idle percentages per side, and a long receiver hold-off in cycles
	int tx_idle_pct = 38;
	int rx_idle_pct = 48;
	int rx_hold = 0;

	rational_arith_reduce_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	// monitor both transfers at the edge
	always @(posedge clk) begin
		if (in_valid && in_ready)
			sb.note(in_data);
		if (out_valid && out_ready)
			sb.check(out_data);
	end

	// receiver: random back-pressure, plus an optional long stall
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// offer one item and hold it until the input transfer, then maybe idle
	task automatic send_item(rar_pkg::in_t it);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!(in_valid && in_ready));
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_frac(logic [2:0] op, int an, int ad, int bn, int bd);
		rar_pkg::in_t it;
		it.opcode = op;
		it.a_num = an[15:0];
		it.a_den = ad[14:0];
		it.b_num = bn[15:0];
		it.b_den = bd[14:0];
		send_item(it);
	endtask

	// numerators: a mix of small values so reductions happen, full range and extremes
	function automatic logic [15:0] pick_num();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'd0;
			3, 4, 5: return 16'($signed($urandom_range(0, 400)) - 200);
			default: return 16'($urandom_range(0, 16'hffff));
		endcase
	endfunction

	function automatic logic [14:0] pick_den();
		case ($urandom_range(19))
			0: return 15'd0;
			1: return 15'h7fff;
			2: return 15'd1;
			3, 4, 5, 6, 7: return 15'($urandom_range(1, 60));
			default: return 15'($urandom_range(1, 15'h7fff));
		endcase
	endfunction

	task automatic send_random(int count);
		rar_pkg::in_t it;
		for (int i = 0; i < count; i++) begin
			// unused opcodes show up now and then
			it.opcode = ($urandom_range(15) == 0) ? 3'($urandom_range(6, 7))
				: 3'($urandom_range(0, 5));
			it.a_num = pick_num();
			it.a_den = pick_den();
			it.b_num = pick_num();
			it.b_den = pick_den();
			send_item(it);
		end
	endtask

	// one edge first so the last input transfer is noted before counting
	task automatic drain_wait();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_frac(rar_pkg::OP_ADD, -32768, 1, 32767, 32767);
		send_frac(rar_pkg::OP_ADD, 1, 2, 1, 2);
		send_frac(rar_pkg::OP_ADD, 32767, 32767, 32767, 32767);
		send_frac(rar_pkg::OP_SUB, 3, 4, 3, 4);
		send_frac(rar_pkg::OP_SUB, -32768, 32767, 32767, 1);
		send_frac(rar_pkg::OP_MUL, -32768, 32767, -32768, 32767);
		send_frac(rar_pkg::OP_MUL, 32767, 1, -32768, 1);
		send_frac(rar_pkg::OP_MUL, 0, 5, 7, 9);
		send_frac(rar_pkg::OP_DIV, 5, 3, 0, 7);              // divide by zero-valued fraction
		send_frac(rar_pkg::OP_DIV, -32768, 1, 0, 32767);
		send_frac(rar_pkg::OP_DIV, 6, 8, -3, 4);             // sign moves to numerator
		send_frac(rar_pkg::OP_DIV, 32767, 1, -32768, 32767);
		send_frac(rar_pkg::OP_NEG, -32768, 1, 0, 1);
		send_frac(rar_pkg::OP_NEG, 10, 4, 1, 1);
		send_frac(rar_pkg::OP_ADD, 3, 0, 1, 2);              // zero input denominator
		send_frac(rar_pkg::OP_NEG, 0, 0, 0, 0);
		send_frac(rar_pkg::OP_CMP, 1, 2, 2, 4);
		send_frac(rar_pkg::OP_CMP, -32768, 1, 32767, 1);
		send_frac(rar_pkg::OP_CMP, 32767, 1, -32768, 32767);
		send_frac(3'd6, 5, 5, 5, 5);
		send_frac(3'd7, -1, 32767, -1, 32767);

		// phase one: sender 38, receiver 48
		send_random(180);
		rx_hold <= 3000;                            // long stall while offering items
		send_random(180);
		drain_wait();                               // sender pause until all results are in
		repeat (300) @(posedge clk);

		// phase two: swapped
		tx_idle_pct = 48;
		rx_idle_pct = 38;
		send_random(360);

		// phase three: no idling
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		send_random(360);

		drain_wait();
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit
	initial begin
		#100000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
